FILE: design/conv2d_bias_clamp_defines.svh
// Assertion macros shared by the checker of conv2d_bias_clamp.
// Depends on nothing; included by the checker file only.
`ifndef CONV2D_BIAS_CLAMP_DEFINES_SVH
`define CONV2D_BIAS_CLAMP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define CBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that a condition holds at every clock edge out of reset.
`define CBC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");
`endif

FILE: design/cbc_pkg.sv
// Package for conv2d_bias_clamp: parameters, request codes, queue entry type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;
  localparam int MaxInW    = 32;
  localparam int MaxInH    = 32;
  localparam int InDepth   = 8;
  localparam int FiltW     = 3;
  localparam int FiltH     = 3;
  localparam int OutDepth  = 16;

  typedef enum logic [1:0] {
    REQ_PIX  = 2'd0,
    REQ_WGT  = 2'd1,
    REQ_BIAS = 2'd2,
    REQ_COMP = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_STRIDE_X = 3'd0,
    CFG_STRIDE_Y = 3'd1,
    CFG_PAD_X    = 3'd2,
    CFG_PAD_Y    = 3'd3,
    CFG_IN_W     = 3'd4,
    CFG_IN_H     = 3'd5,
    CFG_ACT_MIN  = 3'd6,
    CFG_ACT_MAX  = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_FIN  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

  // One compute job passed from the front to the back.
  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [3:0] chan;
  } job_t;

  // Saturate a 32-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    else if (v < -32'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/conv2d_bias_clamp.sv
// conv2d_bias_clamp: direct 2D convolution with bias and activation clamp.
// Input channel (in_valid_i/in_stall_i) carries loads and compute requests.
// Loads write the pixel, weight or bias store in the cycle they transfer.
// Compute requests go to a two-entry queue; a back-end engine pops them.
// The engine pops a request, then runs one multiply-accumulate per cycle
// over the window and input depth, drains the read and multiply registers,
// adds the bias and clamps; it pops the next request only after its result
// is registered.
// Loads stall while a compute request is queued or running.
// Output channel (out_valid_o/out_stall_i): a result waits in its register
// while stalled; the engine then holds its next finished result.
// in_stall_o also rises while the queue is full.
// Reset sets configuration to defaults and clears bias store and control;
// pixel and weight stores stay undefined until written.
// Config port (cfg_valid_i/cfg_ready_o) is always ready; write only when idle.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_bias_clamp #(
  parameter int MAX_IN_W  = cbc_pkg::MaxInW,
  parameter int MAX_IN_H  = cbc_pkg::MaxInH,
  parameter int IN_DEPTH  = cbc_pkg::InDepth,
  parameter int FILT_W    = cbc_pkg::FiltW,
  parameter int FILT_H    = cbc_pkg::FiltH,
  parameter int OUT_DEPTH = cbc_pkg::OutDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [12:0]        index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [4:0]         out_x_i,
  input  wire logic [4:0]         out_y_i,
  input  wire logic [3:0]         out_chan_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      result_value_o,
  output logic [4:0]              res_x_o,
  output logic [4:0]              res_y_o,
  output logic [3:0]              res_chan_o
);
  import cbc_pkg::*;
  logic ld_valid, push, full, pop, avail, eng_busy, busy;
  job_t push_job, head;
  logic [3:0] sx, sy;
  logic [2:0] px, py;
  logic [5:0] iw, ih;
  logic signed [31:0] amin, amax;

  // Any compute queued or in the engine
  assign busy = avail || eng_busy;

  cbc_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .out_x_i, .out_y_i, .out_chan_i,
    .ld_valid_o(ld_valid), .push_o(push), .push_job_o(push_job), .full_i(full),
    .busy_i(busy),
    .stride_x_o(sx), .stride_y_o(sy), .pad_x_o(px), .pad_y_o(py),
    .in_width_o(iw), .in_height_o(ih), .act_min_o(amin), .act_max_o(amax)
  );

  cbc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_job_i(push_job), .full_o(full),
    .pop_i(pop), .avail_o(avail), .head_o(head)
  );

  cbc_engine #(
    .MAX_IN_W(MAX_IN_W), .MAX_IN_H(MAX_IN_H), .IN_DEPTH(IN_DEPTH),
    .FILT_W(FILT_W), .FILT_H(FILT_H), .OUT_DEPTH(OUT_DEPTH)
  ) u_engine (
    .clk_i, .rst_ni, .ld_valid_i(ld_valid), .ld_type_i(req_type_i),
    .ld_index_i(index_i), .ld_value_i(value_i),
    .stride_x_i(sx), .stride_y_i(sy), .pad_x_i(px), .pad_y_i(py),
    .in_width_i(iw), .in_height_i(ih), .act_min_i(amin), .act_max_i(amax),
    .job_avail_i(avail), .job_i(head), .job_pop_o(pop), .busy_o(eng_busy),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i),
    .result_value_o, .res_x_o, .res_y_o, .res_chan_o
  );
endmodule
`default_nettype wire

FILE: design/cbc_queue.sv
// Two-entry job queue between the front and the compute engine.
// Depends on cbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cbc_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               avail_o,
  output cbc_pkg::job_t      head_o
);
  import cbc_pkg::*;
  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rptr_q];

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_job_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

FILE: design/cbc_engine.sv
// Compute engine: owns pixel, weight and bias stores, runs one MAC per cycle.
// Depends on cbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbc_engine #(
  parameter int MAX_IN_W  = cbc_pkg::MaxInW,
  parameter int MAX_IN_H  = cbc_pkg::MaxInH,
  parameter int IN_DEPTH  = cbc_pkg::InDepth,
  parameter int FILT_W    = cbc_pkg::FiltW,
  parameter int FILT_H    = cbc_pkg::FiltH,
  parameter int OUT_DEPTH = cbc_pkg::OutDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // store writes from the front
  input  wire logic                ld_valid_i,
  input  wire logic [1:0]          ld_type_i,
  input  wire logic [12:0]         ld_index_i,
  input  wire logic signed [31:0]  ld_value_i,
  // configuration
  input  wire logic [3:0]          stride_x_i,
  input  wire logic [3:0]          stride_y_i,
  input  wire logic [2:0]          pad_x_i,
  input  wire logic [2:0]          pad_y_i,
  input  wire logic [5:0]          in_width_i,
  input  wire logic [5:0]          in_height_i,
  input  wire logic signed [31:0]  act_min_i,
  input  wire logic signed [31:0]  act_max_i,
  // job queue
  input  wire logic                job_avail_i,
  input  wire cbc_pkg::job_t       job_i,
  output logic                     job_pop_o,
  output logic                     busy_o,
  // result
  output logic                     res_valid_o,
  input  wire logic                res_stall_i,
  output logic signed [31:0]       result_value_o,
  output logic [4:0]               res_x_o,
  output logic [4:0]               res_y_o,
  output logic [3:0]               res_chan_o
);
  import cbc_pkg::*;
  localparam int PixDepth = MAX_IN_W * MAX_IN_H * IN_DEPTH;
  localparam int WgtDepth = OUT_DEPTH * FILT_H * FILT_W * IN_DEPTH;
  localparam int PixAw = $clog2(PixDepth);
  localparam int WgtAw = $clog2(WgtDepth);
  localparam int CW    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int FxW   = (FILT_W > 1) ? $clog2(FILT_W) : 1;
  localparam int FyW   = (FILT_H > 1) ? $clog2(FILT_H) : 1;
  localparam int OcW   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int WW    = $clog2(MAX_IN_W + 1);
  localparam int HW    = $clog2(MAX_IN_H + 1);

  logic signed [15:0] pix_mem [PixDepth];
  logic signed [15:0] wgt_mem [WgtDepth];
  logic signed [31:0] bias_q  [OUT_DEPTH];

  state_e state_q, state_d;
  job_t   job_q;
  logic [CW-1:0]  c_q;
  logic [FxW-1:0] fx_q;
  logic [FyW-1:0] fy_q;
  logic [WgtAw-1:0] wa_q;
  logic signed [11:0] x0_q, y0_q;
  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic last_q, oc_ok_q;
  logic signed [15:0] pix_rd_q, wgt_rd_q;
  logic signed [31:0] prod_q;
  logic prod_v_q, rd_v_q, rd_ok_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] res_q;
  logic res_v_q;

  // Load writes
  always_ff @(posedge clk_i) begin
    if (ld_valid_i && ld_type_i == REQ_PIX && 32'(ld_index_i) < PixDepth)
      pix_mem[ld_index_i[PixAw-1:0]] <= sat16(ld_value_i);
    if (ld_valid_i && ld_type_i == REQ_WGT && 32'(ld_index_i) < WgtDepth)
      wgt_mem[ld_index_i[WgtAw-1:0]] <= sat16(ld_value_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OUT_DEPTH; i++) bias_q[i] <= '0;
    end else if (ld_valid_i && ld_type_i == REQ_BIAS && 32'(ld_index_i) < OUT_DEPTH) begin
      bias_q[ld_index_i[OcW-1:0]] <= ld_value_i;
    end
  end

  // Tap position and validity
  logic signed [11:0] ix, iy;
  logic tap_ok;
  logic [PixAw-1:0] pa;
  assign ix = x0_q + 12'(fx_q);
  assign iy = y0_q + 12'(fy_q);
  assign tap_ok = oc_ok_q && ix >= 0 && iy >= 0 &&
                  ix < $signed(12'(w_q)) && iy < $signed(12'(h_q));
  assign pa = PixAw'(((32'(iy) * MAX_IN_W) + 32'(ix)) * IN_DEPTH + 32'(c_q));

  // Memory reads, registered
  always_ff @(posedge clk_i) begin
    pix_rd_q <= pix_mem[tap_ok ? pa : '0];
    wgt_rd_q <= wgt_mem[oc_ok_q ? wa_q : '0];
    prod_q   <= pix_rd_q * wgt_rd_q;
  end

  logic iter_last;
  assign iter_last = (32'(c_q) == IN_DEPTH - 1) && (32'(fx_q) == FILT_W - 1) &&
                     (32'(fy_q) == FILT_H - 1);

  // Next state
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: if (job_avail_i) begin
        job_pop_o = 1'b1;
        state_d   = ST_RUN;
      end
      ST_RUN:  if (iter_last) state_d = ST_FIN;
      ST_FIN:  if (!rd_v_q && !prod_v_q && last_q) state_d = ST_OUT;
      ST_OUT:  if (!res_v_q || !res_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

  logic signed [63:0] sum, lo64, hi64, floor_sum, clamped;
  assign sum = acc_q + (oc_ok_q ? 64'(bias_q[job_q.chan[OcW-1:0]]) : 64'sd0);
  // Clamp: raise to min, then cut to max
  assign lo64      = 64'(act_min_i);
  assign hi64      = 64'(act_max_i);
  assign floor_sum = (sum < lo64) ? lo64 : sum;
  assign clamped   = (floor_sum > hi64) ? hi64 : floor_sum;

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      res_v_q <= 1'b0;
      last_q  <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= state_q == ST_RUN;
      rd_ok_q  <= tap_ok;
      prod_v_q <= rd_v_q && rd_ok_q;
      if (state_q == ST_RUN && iter_last) last_q <= 1'b1;
      else if (state_q == ST_IDLE) last_q <= 1'b0;
      if (state_q == ST_OUT && state_d == ST_IDLE) res_v_q <= 1'b1;
      else if (!res_stall_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q   <= job_i;
      x0_q    <= $signed(12'(job_i.x) * 12'(stride_x_i)) - $signed(12'(pad_x_i));
      y0_q    <= $signed(12'(job_i.y) * 12'(stride_y_i)) - $signed(12'(pad_y_i));
      w_q     <= (32'(in_width_i) > MAX_IN_W) ? WW'(MAX_IN_W) : WW'(in_width_i);
      h_q     <= (32'(in_height_i) > MAX_IN_H) ? HW'(MAX_IN_H) : HW'(in_height_i);
      oc_ok_q <= 32'(job_i.chan) < OUT_DEPTH;
      wa_q    <= WgtAw'(32'(job_i.chan) * FILT_H * FILT_W * IN_DEPTH);
      c_q <= '0; fx_q <= '0; fy_q <= '0;
      acc_q   <= '0;
    end else begin
      if (state_q == ST_RUN) begin
        wa_q <= wa_q + 1'b1;
        if (32'(c_q) == IN_DEPTH - 1) begin
          c_q <= '0;
          if (32'(fx_q) == FILT_W - 1) begin
            fx_q <= '0;
            fy_q <= fy_q + 1'b1;
          end else fx_q <= fx_q + 1'b1;
        end else c_q <= c_q + 1'b1;
      end
      if (prod_v_q) acc_q <= acc_q + 64'(prod_q);
    end
    // Capture the clamped result and its echo
    if (state_q == ST_OUT && state_d == ST_IDLE) begin
      res_q <= clamped[31:0];
      res_x_o <= job_q.x; res_y_o <= job_q.y; res_chan_o <= job_q.chan;
    end
  end

  assign res_valid_o    = res_v_q;
  assign result_value_o = res_q;
endmodule
`default_nettype wire

FILE: design/cbc_front.sv
// Front end: configuration registers, accepts items, loads or queues jobs.
// Depends on cbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [4:0]         out_x_i,
  input  wire logic [4:0]         out_y_i,
  input  wire logic [3:0]         out_chan_i,
  output logic                    ld_valid_o,
  output logic                    push_o,
  output cbc_pkg::job_t           push_job_o,
  input  wire logic               full_i,
  input  wire logic               busy_i,
  output logic [3:0]              stride_x_o,
  output logic [3:0]              stride_y_o,
  output logic [2:0]              pad_x_o,
  output logic [2:0]              pad_y_o,
  output logic [5:0]              in_width_o,
  output logic [5:0]              in_height_o,
  output logic signed [31:0]      act_min_o,
  output logic signed [31:0]      act_max_o
);
  import cbc_pkg::*;
  logic acc;
  assign cfg_ready_o = 1'b1;
  // Hold loads while a compute is queued or running so stores change in order
  assign in_stall_o  = full_i || (req_type_i != REQ_COMP && busy_i);
  assign acc         = in_valid_i && !in_stall_o;
  assign ld_valid_o  = acc && req_type_i != REQ_COMP;
  assign push_o      = acc && req_type_i == REQ_COMP;
  assign push_job_o  = '{x: out_x_i, y: out_y_i, chan: out_chan_i};

  // Register file write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_x_o <= 4'd1; stride_y_o <= 4'd1;
      pad_x_o <= '0; pad_y_o <= '0;
      in_width_o <= 6'd32; in_height_o <= 6'd32;
      act_min_o <= 32'sh8000_0000; act_max_o <= 32'sh7fff_ffff;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_STRIDE_X: stride_x_o <= cfg_data_i[3:0];
        CFG_STRIDE_Y: stride_y_o <= cfg_data_i[3:0];
        CFG_PAD_X:    pad_x_o <= cfg_data_i[2:0];
        CFG_PAD_Y:    pad_y_o <= cfg_data_i[2:0];
        CFG_IN_W:     in_width_o <= cfg_data_i[5:0];
        CFG_IN_H:     in_height_o <= cfg_data_i[5:0];
        CFG_ACT_MIN:  act_min_o <= cfg_data_i;
        CFG_ACT_MAX:  act_max_o <= cfg_data_i;
        default:      ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/cbc_checker.sv
// Port-level checker for conv2d_bias_clamp, bound to the top level.
// Depends on conv2d_bias_clamp_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_bias_clamp_defines.svh"
module cbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] result_value_o,
  input wire logic [4:0]  res_x_o
);
  // Hold a stalled result
  `CBC_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CBC_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(result_value_o) && $stable(res_x_o))
  // Config is always taken
  `CBC_ASSERT_ALWAYS(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
endmodule
bind conv2d_bias_clamp cbc_checker u_cbc_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .out_valid_o, .out_stall_i, .result_value_o, .res_x_o
);
`default_nettype wire

FILE: tb/sv/cbc_conv_predictor.sv
// Predictor and result comparator for conv2d_bias_clamp: watches the config,
// request and result channels, predicts each result and counts mismatches.
// Depends on cbc_pkg for sizes and the request and register codes.
`timescale 1ns / 1ps
module cbc_conv_predictor
  import cbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         req_type_i,
  input  logic [12:0]        index_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         out_x_i,
  input  logic [4:0]         out_y_i,
  input  logic [3:0]         out_chan_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] result_value_i,
  input  logic [4:0]         res_x_i,
  input  logic [4:0]         res_y_i,
  input  logic [3:0]         res_chan_i,
  output int                 mismatches_o,
  output int                 awaiting_o
);
  localparam int PixCount = MaxInW * MaxInH * InDepth;
  localparam int WgtCount = OutDepth * FiltH * FiltW * InDepth;

  typedef struct {
    logic signed [31:0] value;
    logic [4:0]         x;
    logic [4:0]         y;
    logic [3:0]         chan;
  } conv_out_t;

  logic signed [15:0] pix_mem [PixCount];
  logic signed [15:0] wgt_mem [WgtCount];
  logic signed [31:0] bias_mem [OutDepth];
  logic [3:0]         stride_x, stride_y;
  logic [2:0]         pad_x, pad_y;
  logic [5:0]         in_w, in_h;
  logic signed [31:0] act_min, act_max;
  conv_out_t          conv_outs_due [$];

  initial begin
    foreach (pix_mem[i]) pix_mem[i] = '0;
    foreach (wgt_mem[i]) wgt_mem[i] = '0;
  end

  function automatic logic signed [15:0] clip16(logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Sum the window over all input channels, add bias, then clamp.
  function automatic logic signed [31:0] conv_sum_at(logic [4:0] ox, logic [4:0] oy,
                                                     logic [3:0] oc);
    int     w, h, x0, y0, iy, ix;
    longint acc, lo, hi;
    w = (in_w > MaxInW) ? MaxInW : int'(in_w);
    h = (in_h > MaxInH) ? MaxInH : int'(in_h);
    x0 = int'(ox) * int'(stride_x) - int'(pad_x);
    y0 = int'(oy) * int'(stride_y) - int'(pad_y);
    acc = 0;
    for (int fy = 0; fy < FiltH; fy++) begin
      iy = y0 + fy;
      if (iy < 0 || iy >= h) continue;
      for (int fx = 0; fx < FiltW; fx++) begin
        ix = x0 + fx;
        if (ix < 0 || ix >= w) continue;
        for (int c = 0; c < InDepth; c++) begin
          acc += longint'(pix_mem[(iy * MaxInW + ix) * InDepth + c]) *
                 longint'(wgt_mem[((int'(oc) * FiltH + fy) * FiltW + fx) * InDepth + c]);
        end
      end
    end
    acc += longint'(bias_mem[oc]);
    lo = longint'(act_min);
    hi = longint'(act_max);
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    return acc[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_out_t due;
    if (!rst_ni) begin
      stride_x = 4'd1;
      stride_y = 4'd1;
      pad_x = '0;
      pad_y = '0;
      in_w = 6'd32;
      in_h = 6'd32;
      act_min = 32'sh8000_0000;
      act_max = 32'sh7fff_ffff;
      foreach (bias_mem[i]) bias_mem[i] = '0;
      conv_outs_due.delete();
      mismatches_o = 0;
      awaiting_o = 0;
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_STRIDE_X: stride_x = cfg_data_i[3:0];
          CFG_STRIDE_Y: stride_y = cfg_data_i[3:0];
          CFG_PAD_X:    pad_x = cfg_data_i[2:0];
          CFG_PAD_Y:    pad_y = cfg_data_i[2:0];
          CFG_IN_W:     in_w = cfg_data_i[5:0];
          CFG_IN_H:     in_h = cfg_data_i[5:0];
          CFG_ACT_MIN:  act_min = cfg_data_i;
          CFG_ACT_MAX:  act_max = cfg_data_i;
          default: ;
        endcase
      end
      // Apply loads and predict computes at request transfer
      if (in_valid_i && !in_stall_i) begin
        case (req_e'(req_type_i))
          REQ_PIX:  pix_mem[index_i] = clip16(value_i);
          REQ_WGT:  if (index_i < WgtCount) wgt_mem[index_i] = clip16(value_i);
          REQ_BIAS: if (index_i < OutDepth) bias_mem[index_i[3:0]] = value_i;
          REQ_COMP: begin
            due.value = conv_sum_at(out_x_i, out_y_i, out_chan_i);
            due.x = out_x_i;
            due.y = out_y_i;
            due.chan = out_chan_i;
            conv_outs_due.push_back(due);
          end
          default: ;
        endcase
      end
      // Compare each result transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (conv_outs_due.size() == 0) begin
          $display("%0t: unexpected result value=%0d x=%0d y=%0d chan=%0d",
                   $time, result_value_i, res_x_i, res_y_i, res_chan_i);
          mismatches_o++;
        end else begin
          due = conv_outs_due.pop_front();
          if (due.value !== result_value_i) begin
            $display("%0t: result_value expected %0d got %0d", $time, due.value,
                     result_value_i);
            mismatches_o++;
          end
          if (due.x !== res_x_i) begin
            $display("%0t: res_x expected %0d got %0d", $time, due.x, res_x_i);
            mismatches_o++;
          end
          if (due.y !== res_y_i) begin
            $display("%0t: res_y expected %0d got %0d", $time, due.y, res_y_i);
            mismatches_o++;
          end
          if (due.chan !== res_chan_i) begin
            $display("%0t: res_chan expected %0d got %0d", $time, due.chan, res_chan_i);
            mismatches_o++;
          end
        end
      end
      awaiting_o = conv_outs_due.size();
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Top of the conv2d_bias_clamp testbench: clock, reset, stimulus and verdict.
// Depends on cbc_pkg, the block and cbc_conv_predictor.
`timescale 1ns / 1ps
module tb_top;
  import cbc_pkg::*;

  localparam int PixCount = MaxInW * MaxInH * InDepth;
  localparam int WgtCount = OutDepth * FiltH * FiltW * InDepth;
  localparam int ItemTarget = 1300;
  localparam int DrainCycles = 120;

  logic               clk, rst_n;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_stall;
  logic [1:0]         req_type;
  logic [12:0]        index;
  logic signed [31:0] value;
  logic [4:0]         out_x, out_y;
  logic [3:0]         out_chan;
  logic               out_valid, out_stall;
  logic signed [31:0] result_value;
  logic [4:0]         res_x, res_y;
  logic [3:0]         res_chan;
  int                 mismatches, awaiting;

  // Mirror of the register settings, used to pick windows and fill taps
  int  cur_sx, cur_sy, cur_px, cur_py, cur_w, cur_h;
  bit  pix_loaded [PixCount];
  bit  wgt_loaded [WgtCount];
  int  send_idle_pct, stall_pct, items_sent;

  conv2d_bias_clamp u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .index_i(index), .value_i(value),
    .out_x_i(out_x), .out_y_i(out_y), .out_chan_i(out_chan),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_value_o(result_value), .res_x_o(res_x), .res_y_o(res_y),
    .res_chan_o(res_chan)
  );

  cbc_conv_predictor u_predictor (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .index_i(index), .value_i(value),
    .out_x_i(out_x), .out_y_i(out_y), .out_chan_i(out_chan),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .result_value_i(result_value), .res_x_i(res_x), .res_y_i(res_y),
    .res_chan_i(res_chan),
    .mismatches_o(mismatches), .awaiting_o(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #30ms;
    $display("[conv2d_bias_clamp] ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_7fff;
      3: return 32'hffff_8000;
      4, 5: return $urandom;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic int pick_coord(int stride, int pad, int size);
    int hi;
    if (stride == 0 || $urandom_range(0, 99) < 20) return $urandom_range(0, 31);
    hi = (size + pad) / stride;
    if (hi > 31) hi = 31;
    return $urandom_range(0, hi);
  endfunction

  task automatic send(req_e kind, int idx, logic [31:0] val, int x, int y, int ch,
                      bit counted);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    index <= idx[12:0];
    value <= val;
    out_x <= x[4:0];
    out_y <= y[4:0];
    out_chan <= ch[3:0];
    do @(posedge clk); while (in_stall);
    if (counted) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e reg_id, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= reg_id;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drain, let the engine settle, then write every register
  task automatic configure(int sx, int sy, int px, int py, int w, int h,
                           logic [31:0] lo, logic [31:0] hi);
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    write_reg(CFG_STRIDE_X, sx);
    write_reg(CFG_STRIDE_Y, sy);
    write_reg(CFG_PAD_X, px);
    write_reg(CFG_PAD_Y, py);
    write_reg(CFG_IN_W, w);
    write_reg(CFG_IN_H, h);
    write_reg(CFG_ACT_MIN, lo);
    write_reg(CFG_ACT_MAX, hi);
    cur_sx = sx; cur_sy = sy; cur_px = px; cur_py = py;
    cur_w = (w > MaxInW) ? MaxInW : w;
    cur_h = (h > MaxInH) ? MaxInH : h;
  endtask

  // Load any never-written entry that this window will read, then compute
  task automatic compute(int x, int y, int ch);
    int x0, y0, ix, iy, pa, wa;
    x0 = x * cur_sx - cur_px;
    y0 = y * cur_sy - cur_py;
    for (int fy = 0; fy < FiltH; fy++) begin
      iy = y0 + fy;
      if (iy < 0 || iy >= cur_h) continue;
      for (int fx = 0; fx < FiltW; fx++) begin
        ix = x0 + fx;
        if (ix < 0 || ix >= cur_w) continue;
        for (int c = 0; c < InDepth; c++) begin
          pa = (iy * MaxInW + ix) * InDepth + c;
          wa = ((ch * FiltH + fy) * FiltW + fx) * InDepth + c;
          if (!pix_loaded[pa]) begin
            send(REQ_PIX, pa, pick_value(), $urandom, $urandom, $urandom, 1'b1);
            pix_loaded[pa] = 1'b1;
          end
          if (!wgt_loaded[wa]) begin
            send(REQ_WGT, wa, pick_value(), $urandom, $urandom, $urandom, 1'b1);
            wgt_loaded[wa] = 1'b1;
          end
        end
      end
    end
    send(REQ_COMP, $urandom, $urandom, x, y, ch, 1'b1);
  endtask

  // Overwrite stored data only while no compute is in flight
  task automatic reload_burst();
    int n, a;
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: begin
          a = $urandom_range(0, PixCount - 1);
          send(REQ_PIX, a, pick_value(), $urandom, $urandom, $urandom, 1'b1);
          pix_loaded[a] = 1'b1;
        end
        1: begin
          a = $urandom_range(0, WgtCount - 1);
          send(REQ_WGT, a, pick_value(), $urandom, $urandom, $urandom, 1'b1);
          wgt_loaded[a] = 1'b1;
        end
        default: send(REQ_BIAS, $urandom_range(0, OutDepth - 1), pick_value(),
                      $urandom, $urandom, $urandom, 1'b1);
      endcase
    end
  endtask

  task automatic random_config(int phase);
    logic [31:0] lo, hi, t;
    int          w, h;
    case ($urandom_range(0, 3))
      0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
      1: begin
        lo = $urandom; hi = $urandom;
        if ($signed(lo) > $signed(hi)) begin t = lo; lo = hi; hi = t; end
      end
      2: begin lo = $urandom; hi = $urandom; end
      default: begin
        lo = -($urandom_range(0, 1000) << 10);
        hi = $urandom_range(0, 1000) << 10;
      end
    endcase
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
    configure($urandom_range(0, 99) < 80 ? $urandom_range(1, 3) : $urandom_range(0, 15),
              $urandom_range(0, 99) < 80 ? $urandom_range(1, 3) : $urandom_range(0, 15),
              $urandom_range(0, 7), $urandom_range(0, 7), w, h, lo, hi);
    case (phase % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 68; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 68; end
      default: begin send_idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  initial begin
    int phase, roll, next_phase_at;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_PIX;
    index = '0;
    value = '0;
    out_x = '0;
    out_y = '0;
    out_chan = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bias extremes, corners, padding, crossed clamps, zero stride and size
    configure(1, 1, 1, 1, 3, 3, 32'h8000_0000, 32'h7fff_ffff);
    compute(0, 0, 0);
    send(REQ_BIAS, 0, 32'h7fff_ffff, 0, 0, 0, 1'b1);
    send(REQ_BIAS, OutDepth - 1, 32'h8000_0000, 0, 0, 0, 1'b1);
    send(REQ_BIAS, 8191, 32'h1234_5678, 0, 0, 0, 1'b0);
    send(REQ_WGT, 8191, 32'h7fff_ffff, 0, 0, 0, 1'b0);
    compute(0, 0, 0);
    compute(1, 1, OutDepth - 1);
    compute(31, 31, OutDepth - 1);
    configure(0, 0, 7, 7, 3, 3, 32'd100, -32'sd100);
    compute(1, 1, 3);
    compute(31, 31, 0);
    configure(15, 15, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    compute(5, 5, 7);
    configure(15, 15, 7, 7, 63, 63, 32'h8000_0000, 32'h7fff_ffff);
    compute(2, 2, 1);
    compute(0, 0, 2);

    // Random: mostly window computes, some ignored loads and idle-time reloads
    phase = 0;
    next_phase_at = items_sent;
    while (items_sent < ItemTarget) begin
      if (items_sent >= next_phase_at) begin
        phase++;
        random_config(phase);
        next_phase_at = items_sent + 120;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75)
        compute(pick_coord(cur_sx, cur_px, cur_w), pick_coord(cur_sy, cur_py, cur_h),
                $urandom_range(0, OutDepth - 1));
      else if (roll < 85)
        send($urandom_range(0, 1) ? REQ_WGT : REQ_BIAS,
             $urandom_range(WgtCount, 8191), $urandom, $urandom, $urandom, $urandom, 1'b0);
      else
        reload_burst();
    end

    // Drain and give the verdict
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("[conv2d_bias_clamp] OK");
    end else begin
      $display("[conv2d_bias_clamp] ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/cbc_pkg.sv
design/cbc_queue.sv
design/cbc_engine.sv
design/cbc_front.sv
design/conv2d_bias_clamp.sv
design/cbc_checker.sv
tb/sv/cbc_conv_predictor.sv
tb/sv/tb_top.sv
